FILE: src/lzbd_pkg.sv
// Shared types, constants and length-class tables for the LZ77 bitstream decompressor.
package lzbd_pkg;

   // Result word geometry
   localparam int BYTES_PER_RESULT = 16;
   localparam int LANE_W           = 4;   // index of one byte lane
   localparam int FILL_W           = 5;   // 0..16 bytes held
   localparam int LEN_W            = 10;  // copy length 3..566
   localparam int CLASS_W          = 3;   // length class 0..5

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_DIST  = 2'd1;
   localparam logic [1:0] ST_HDR   = 2'd2;
   localparam logic [1:0] ST_EARLY = 2'd3;

   // One parsed token, as seen by the control logic
   typedef struct packed {
      logic             complete;
      logic             is_match;
      logic [7:0]       lit;
      logic [LEN_W-1:0] len;
   } token_type;

   // Extra bits that follow the unary prefix of each length class
   function automatic logic [3:0] class_bits(input logic [CLASS_W-1:0] k);
      logic [3:0] r;
      case (k)
         3'd0:    r = 4'd2;
         3'd1:    r = 4'd2;
         3'd2:    r = 4'd2;
         3'd3:    r = 4'd3;
         3'd4:    r = 4'd5;
         3'd5:    r = 4'd9;
         default: r = 4'd2;
      endcase
      return r;
   endfunction

   // Base length of each class
   function automatic logic [5:0] class_base(input logic [CLASS_W-1:0] k);
      logic [5:0] r;
      case (k)
         3'd0:    r = 6'd0;
         3'd1:    r = 6'd4;
         3'd2:    r = 6'd8;
         3'd3:    r = 6'd12;
         3'd4:    r = 6'd20;
         3'd5:    r = 6'd52;
         default: r = 6'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: src/lzbd_if.sv
// Valid/ready channel interfaces: compressed input, decoded results, register write.
interface lzbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       stream_start;
   logic       stream_end;
   modport source (output valid, in_byte, stream_start, stream_end, input ready);
   modport sink   (input valid, in_byte, stream_start, stream_end, output ready);
endinterface

interface lzbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_bytes_low;
   logic [63:0] out_bytes_high;
   logic [4:0]  byte_count;
   logic        last_of_run;
   logic        stream_done;
   logic [1:0]  status;
   modport source (output valid, out_bytes_low, out_bytes_high, byte_count, last_of_run,
                   stream_done, status, input ready);
   modport sink   (input valid, out_bytes_low, out_bytes_high, byte_count, last_of_run,
                   stream_done, status, output ready);
endinterface

interface lzbd_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: src/lzbd_history.sv
// History window: single write port, single read port, registered read data.
module lzbd_history #(
   parameter int WINDOW_BITS = 18
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [WINDOW_BITS-1:0] wr_addr,
   input  logic [7:0]             wr_data,
   input  logic [WINDOW_BITS-1:0] rd_addr,
   output logic [7:0]             rd_data
);

   logic [7:0] mem [2**WINDOW_BITS];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/lzbd_parser.sv
// Token decoder: looks at the pending bit buffer and splits off one literal or match.
module lzbd_parser #(
   parameter int  WINDOW_BITS = 18,
   localparam int PEND_W      = WINDOW_BITS + 25,
   localparam int CNT_W       = $clog2(PEND_W + 1)
) (
   input  logic [PEND_W-1:0]      pend_bits,
   input  logic [CNT_W-1:0]       pend_count,
   output lzbd_pkg::token_type    token,
   output logic [WINDOW_BITS:0]   distance,
   output logic [CNT_W-1:0]       used
);

   logic [lzbd_pkg::CLASS_W-1:0] k;
   logic [CNT_W-1:0]             pos1, pos2, pos3, used_match;
   logic [3:0]                   cb;
   logic [PEND_W-1:0]            sh_cls, sh_slot, sh_dist;
   logic [8:0]                   v_cls;
   logic [3:0]                   slot;
   logic [4:0]                   lg;
   logic [WINDOW_BITS-1:0]       v_dist, off, lg_bit;

   always_comb begin
      // unary prefix: first one among the five bits after the flag
      k = 3'd5;
      for (int i = 4; i >= 0; i--) begin
         if (pend_bits[i+1]) begin
            k = 3'(i);
         end
      end
      pos1 = (k == 3'd5) ? CNT_W'(6) : CNT_W'(k) + CNT_W'(2);
      cb   = lzbd_pkg::class_bits(k);

      // length field
      sh_cls = pend_bits >> pos1;
      v_cls  = sh_cls[8:0] & 9'((10'd1 << cb) - 10'd1);
      pos2   = pos1 + CNT_W'(cb);

      // distance slot and distance bits
      sh_slot = pend_bits >> pos2;
      slot    = sh_slot[3:0];
      pos3    = pos2 + CNT_W'(4);
      lg      = (slot != 4'd0) ? 5'(slot) + 5'(WINDOW_BITS - 16) : 5'(WINDOW_BITS - 15);
      lg_bit  = WINDOW_BITS'(1) << lg;
      sh_dist = pend_bits >> pos3;
      v_dist  = sh_dist[WINDOW_BITS-1:0] & (lg_bit - WINDOW_BITS'(1));
      off     = (slot != 4'd0) ? v_dist + lg_bit : v_dist;
      used_match = pos3 + CNT_W'(lg);

      token.is_match = pend_bits[0];
      token.lit      = pend_bits[8:1];
      token.len      = lzbd_pkg::LEN_W'(v_cls) + lzbd_pkg::LEN_W'(lzbd_pkg::class_base(k))
                       + lzbd_pkg::LEN_W'(3);
      distance       = (WINDOW_BITS+1)'(off) + (WINDOW_BITS+1)'(1);
      used           = pend_bits[0] ? used_match : CNT_W'(9);
      // bits past the count are zero, so a short buffer always reads as incomplete
      token.complete = (pend_count != '0) && (used <= pend_count);
   end

endmodule

FILE: src/lz77_bitstream_decompressor_unit.sv
// Top level of the LZ77 bitstream decompressor: control sequencer, output packing.
//
// Channels: req carries one compressed byte per word (bits used LSB first) with
// stream_start / stream_end marks; rsp carries up to 16 decoded bytes per word plus
// count, last-of-run, done and status; csr writes the 32-bit output size cap
// (zero = header size), taken when the fourth header byte is processed.
// One input word is handled at a time. A header byte passes through the step and
// final states before req is ready again, a byte that completes no token through
// step, parse and final. A literal adds one pass through parse; a match copy walks
// the history memory one byte per cycle while the packer has room, through its
// single read port (registered read data, same-entry reads forwarded), and hands
// each full 16-byte result word over while more of the copy remains. Every input
// word gives at least one result; the last one carries last_of_run.
// Reset clears all control state and the size cap; the history memory is not
// cleared, the distance check keeps reads to written entries.
// When rsp is stalled the single output register holds its word; the copy stops
// once the 16-byte packer is full, and req is not taken until the input word's
// last result has been loaded into the output register.
module lz77_bitstream_decompressor_unit #(
   parameter int WINDOW_BITS = 18
) (
   input logic              clock,
   input logic              reset,
   lzbd_req_if.sink         req,
   lzbd_rsp_if.source       rsp,
   lzbd_csr_if.sink         csr
);

   localparam int PEND_W   = WINDOW_BITS + 25;
   localparam int CNT_W    = $clog2(PEND_W + 1);
   localparam int NB       = lzbd_pkg::BYTES_PER_RESULT;
   localparam int LANE_IDX = lzbd_pkg::LANE_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_STEP  = 3'd1;
   localparam logic [2:0] S_PARSE = 3'd2;
   localparam logic [2:0] S_COPY  = 3'd3;
   localparam logic [2:0] S_FINAL = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [31:0]                  limit_ff, limit_in;
   logic [7:0]                   byte_ff, byte_in;
   logic                         end_ff, end_in;
   logic [PEND_W-1:0]            pend_ff, pend_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [2:0]                   hdr_ff, hdr_in;
   logic [31:0]                  exp_ff, exp_in;
   logic [31:0]                  prod_ff, prod_in;
   logic [1:0]                   status_ff, status_in;
   logic                         fin_ff, fin_in;
   logic [lzbd_pkg::LEN_W-1:0]   rem_ff, rem_in;
   logic [WINDOW_BITS:0]         dist_ff, dist_in;
   logic                         pred_done_ff, pred_done_in;
   logic [1:0]                   pred_status_ff, pred_status_in;
   logic                         inflight_ff, inflight_in;
   logic                         fwd_ff, fwd_in;
   logic [7:0]                   fwd_data_ff, fwd_data_in;
   logic [7:0]                   acc_ff [NB];
   logic [7:0]                   acc_in [NB];
   logic [lzbd_pkg::FILL_W-1:0]  fill_ff, fill_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [63:0]                  out_low_ff, out_low_in, out_high_ff, out_high_in;
   logic [4:0]                   out_count_ff, out_count_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_done_ff, out_done_in;
   logic [1:0]                   out_status_ff, out_status_in;

   lzbd_pkg::token_type          tok;
   logic [WINDOW_BITS:0]         tok_dist;
   logic [CNT_W-1:0]             tok_used;
   logic                         mem_we;
   logic [WINDOW_BITS-1:0]       mem_waddr, mem_raddr;
   logic [7:0]                   mem_wdata, mem_rdata;

   logic                         out_free, emit_v, issue, fin_eff;
   logic [7:0]                   byte_e;
   logic [lzbd_pkg::FILL_W-1:0]  fill_after;
   logic [31:0]                  exp_new, clipped, room;
   logic [1:0]                   status_eff;
   logic [63:0]                  acc_low, acc_high;

   lzbd_parser #(.WINDOW_BITS(WINDOW_BITS)) u_parser (
      .pend_bits  (pend_ff),
      .pend_count (cnt_ff),
      .token      (tok),
      .distance   (tok_dist),
      .used       (tok_used)
   );

   lzbd_history #(.WINDOW_BITS(WINDOW_BITS)) u_history (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // handshakes
   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // byte arriving from the history read, forwarded when it was just written
   assign byte_e     = fwd_ff ? fwd_data_ff : mem_rdata;
   assign emit_v     = inflight_ff;
   assign fill_after = fill_ff + lzbd_pkg::FILL_W'(emit_v);

   // end-of-word flags
   assign fin_eff    = fin_ff || end_ff;
   assign status_eff = (!fin_ff && end_ff) ?
                       ((hdr_ff < 3'd4) ? lzbd_pkg::ST_HDR : lzbd_pkg::ST_EARLY) : status_ff;

   // header assembly and size cap
   assign exp_new = exp_ff | (32'(byte_ff) << {hdr_ff[1:0], 3'b000});
   assign clipped = (limit_ff != 32'd0 && exp_new > limit_ff) ? limit_ff : exp_new;
   assign room    = exp_ff - prod_ff;

   // packer lanes to result halves
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         acc_low[8*i +: 8]  = acc_ff[i];
         acc_high[8*i +: 8] = acc_ff[i+8];
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      limit_in       = limit_ff;
      byte_in        = byte_ff;
      end_in         = end_ff;
      pend_in        = pend_ff;
      cnt_in         = cnt_ff;
      hdr_in         = hdr_ff;
      exp_in         = exp_ff;
      prod_in        = prod_ff;
      status_in      = status_ff;
      fin_in         = fin_ff;
      rem_in         = rem_ff;
      dist_in        = dist_ff;
      pred_done_in   = pred_done_ff;
      pred_status_in = pred_status_ff;
      inflight_in    = 1'b0;
      fwd_in         = 1'b0;
      fwd_data_in    = byte_e;
      acc_in         = acc_ff;
      fill_in        = fill_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      out_low_in     = out_low_ff;
      out_high_in    = out_high_ff;
      out_count_in   = out_count_ff;
      out_last_in    = out_last_ff;
      out_done_in    = out_done_ff;
      out_status_in  = out_status_ff;
      mem_we         = 1'b0;
      mem_waddr      = prod_ff[WINDOW_BITS-1:0];
      mem_wdata      = byte_e;
      mem_raddr      = prod_ff[WINDOW_BITS-1:0] + WINDOW_BITS'(emit_v)
                       - dist_ff[WINDOW_BITS-1:0];
      issue          = 1'b0;

      if (csr.valid) begin
         limit_in = csr.data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               byte_in  = req.in_byte;
               end_in   = req.stream_end;
               state_in = S_STEP;
               if (req.stream_start) begin
                  pend_in   = '0;
                  cnt_in    = '0;
                  hdr_in    = '0;
                  exp_in    = '0;
                  prod_in   = '0;
                  status_in = lzbd_pkg::ST_OK;
                  fin_in    = 1'b0;
               end
            end
         end
         S_STEP: begin
            if (fin_ff) begin
               state_in = S_FINAL;
            end else if (hdr_ff < 3'd4) begin
               hdr_in   = hdr_ff + 3'd1;
               exp_in   = exp_new;
               state_in = S_FINAL;
               if (hdr_ff == 3'd3) begin
                  exp_in = clipped;
                  fin_in = (clipped == 32'd0);
               end
            end else begin
               pend_in  = pend_ff | (PEND_W'(byte_ff) << cnt_ff);
               cnt_in   = cnt_ff + CNT_W'(8);
               state_in = S_PARSE;
            end
         end
         S_PARSE: begin
            if (fin_ff || !tok.complete) begin
               state_in = S_FINAL;
            end else begin
               pend_in = pend_ff >> tok_used;
               cnt_in  = cnt_ff - tok_used;
               if (!tok.is_match) begin
                  // literal straight into the packer and the window
                  mem_we                         = 1'b1;
                  mem_wdata                      = tok.lit;
                  acc_in[fill_ff[LANE_IDX-1:0]] = tok.lit;
                  fill_in                        = fill_ff + lzbd_pkg::FILL_W'(1);
                  prod_in                        = prod_ff + 32'd1;
                  fin_in                         = (prod_ff + 32'd1 >= exp_ff);
               end else if (32'(tok_dist) > prod_ff) begin
                  status_in = lzbd_pkg::ST_DIST;
                  fin_in    = 1'b1;
                  state_in  = S_FINAL;
               end else begin
                  // copy length clipped to the bytes still owed
                  dist_in        = tok_dist;
                  rem_in         = (32'(tok.len) >= room) ? lzbd_pkg::LEN_W'(room) : tok.len;
                  pred_done_in   = (32'(tok.len) >= room) || end_ff;
                  pred_status_in = (32'(tok.len) < room && end_ff) ?
                                   lzbd_pkg::ST_EARLY : lzbd_pkg::ST_OK;
                  state_in       = S_COPY;
               end
            end
         end
         S_COPY: begin
            // write back the byte read last cycle
            if (emit_v) begin
               mem_we                         = 1'b1;
               acc_in[fill_ff[LANE_IDX-1:0]] = byte_e;
               fill_in                        = fill_after;
               prod_in                        = prod_ff + 32'd1;
            end
            // next read only when the packer will have room for it
            issue       = (rem_ff != '0) && (fill_after < lzbd_pkg::FILL_W'(NB));
            inflight_in = issue;
            fwd_in      = issue && emit_v && (mem_raddr == prod_ff[WINDOW_BITS-1:0]);
            if (issue) begin
               rem_in = rem_ff - lzbd_pkg::LEN_W'(1);
            end
            // full packer with more bytes to come goes out as a middle word
            if (fill_ff == lzbd_pkg::FILL_W'(NB) && rem_ff != '0 && out_free) begin
               rsp_valid_in  = 1'b1;
               out_low_in    = acc_low;
               out_high_in   = acc_high;
               out_count_in  = fill_ff;
               out_last_in   = 1'b0;
               out_done_in   = pred_done_ff;
               out_status_in = pred_status_ff;
               fill_in       = '0;
               for (int i = 0; i < NB; i++) begin
                  acc_in[i] = 8'd0;
               end
            end
            if (rem_ff == '0 && !inflight_ff) begin
               fin_in   = (prod_ff >= exp_ff);
               state_in = S_PARSE;
            end
         end
         S_FINAL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_low_in    = acc_low;
               out_high_in   = acc_high;
               out_count_in  = fill_ff;
               out_last_in   = 1'b1;
               out_done_in   = fin_eff;
               out_status_in = status_eff;
               fin_in        = fin_eff;
               status_in     = status_eff;
               fill_in       = '0;
               for (int i = 0; i < NB; i++) begin
                  acc_in[i] = 8'd0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         limit_ff     <= '0;
         pend_ff      <= '0;
         cnt_ff       <= '0;
         hdr_ff       <= '0;
         exp_ff       <= '0;
         prod_ff      <= '0;
         status_ff    <= lzbd_pkg::ST_OK;
         fin_ff       <= 1'b0;
         rem_ff       <= '0;
         inflight_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NB; i++) begin
            acc_ff[i] <= 8'd0;
         end
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         hdr_ff       <= hdr_in;
         exp_ff       <= exp_in;
         prod_ff      <= prod_in;
         status_ff    <= status_in;
         fin_ff       <= fin_in;
         rem_ff       <= rem_in;
         inflight_ff  <= inflight_in;
         fwd_ff       <= fwd_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
      end
      byte_ff        <= byte_in;
      end_ff         <= end_in;
      dist_ff        <= dist_in;
      pred_done_ff   <= pred_done_in;
      pred_status_ff <= pred_status_in;
      fwd_data_ff    <= fwd_data_in;
      out_low_ff     <= out_low_in;
      out_high_ff    <= out_high_in;
      out_count_ff   <= out_count_in;
      out_last_ff    <= out_last_in;
      out_done_ff    <= out_done_in;
      out_status_ff  <= out_status_in;
   end

   // result port
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.out_bytes_low  = out_low_ff;
   assign rsp.out_bytes_high = out_high_ff;
   assign rsp.byte_count     = out_count_ff;
   assign rsp.last_of_run    = out_last_ff;
   assign rsp.stream_done    = out_done_ff;
   assign rsp.status         = out_status_ff;

   // packer never overfills
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= lzbd_pkg::FILL_W'(NB))
      else $error("packer fill above one result word");

   // a history read is only outstanding during a copy
   a_inflight_copy: assert property (@(posedge clock) disable iff (reset)
      inflight_ff |-> state_ff == S_COPY)
      else $error("history read outstanding outside copy");

   // a full packer never has a read in flight
   a_full_no_read: assert property (@(posedge clock) disable iff (reset)
      fill_ff == lzbd_pkg::FILL_W'(NB) |-> !inflight_ff)
      else $error("read issued with no room in packer");

   // middle result words are always full
   a_mid_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !out_last_ff |-> out_count_ff == 5'(NB))
      else $error("partial result word without last_of_run");

   // decoded count never passes the size
   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      hdr_ff == 3'd4 |-> prod_ff <= exp_ff)
      else $error("decoded bytes beyond stream size");

endmodule
